// ===== hw/rtl/gregorian_date_difference_macros.svh =====
// Assertion macros used by the file that checks the block.
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define GDD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

// ===== hw/rtl/gdd_pkg.sv =====
`timescale 1ns / 1ps

package gdd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int YY_W     = 15;
	localparam int Q_W      = 8;
	localparam int DN_W     = 23;
	localparam int COUNT_W  = 22;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;
	localparam logic [YY_W-1:0] YEAR_OFFSET = 15'd400;

	// Reciprocal of 25 scaled by two to the seventeenth; exact for the quarter-years used.
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam int RECIP_SHIFT = 17;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	typedef struct packed {
		logic load;
		logic div;
		logic day;
		logic fin;
		logic sel_end;
	} gdd_cmd_t;

	typedef struct packed {
		logic out_stall;
	} gdd_status_t;

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days before the first of the month, counting the year from March.
	function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [8:0] off;
		case (m)
			4'd3: off = 9'd0;
			4'd4: off = 9'd31;
			4'd5: off = 9'd61;
			4'd6: off = 9'd92;
			4'd7: off = 9'd122;
			4'd8: off = 9'd153;
			4'd9: off = 9'd184;
			4'd10: off = 9'd214;
			4'd11: off = 9'd245;
			4'd12: off = 9'd275;
			4'd1: off = 9'd306;
			4'd2: off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

// ===== hw/rtl/gdd_in_if.sv =====
`timescale 1ns / 1ps

interface gdd_in_if;
	logic valid;
	logic ready;
	logic [4:0] start_day;
	logic [3:0] start_month;
	logic [13:0] start_year;
	logic [4:0] end_day;
	logic [3:0] end_month;
	logic [13:0] end_year;
	logic include_end_day;

	modport source (
		output valid, start_day, start_month, start_year,
		output end_day, end_month, end_year, include_end_day,
		input ready
	);

	modport sink (
		input valid, start_day, start_month, start_year,
		input end_day, end_month, end_year, include_end_day,
		output ready
	);
endinterface

// ===== hw/rtl/gdd_out_if.sv =====
`timescale 1ns / 1ps

interface gdd_out_if;
	logic valid;
	logic ready;
	logic [21:0] day_count;
	logic invalid_date;

	modport source (
		output valid, day_count, invalid_date,
		input ready
	);

	modport sink (
		input valid, day_count, invalid_date,
		output ready
	);
endinterface

// ===== hw/rtl/gdd_ctrl.sv =====
`timescale 1ns / 1ps

module gdd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input gdd_pkg::gdd_status_t status,
	output gdd_pkg::gdd_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV_S = 6'b000010,
		ST_DAY_S = 6'b000100,
		ST_DIV_E = 6'b001000,
		ST_DAY_E = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DIV_S;
				end
			end
			ST_DIV_S: begin
				cmd.div = 1'b1;
				state_d = ST_DAY_S;
			end
			ST_DAY_S: begin
				cmd.day = 1'b1;
				state_d = ST_DIV_E;
			end
			ST_DIV_E: begin
				cmd.div = 1'b1;
				cmd.sel_end = 1'b1;
				state_d = ST_DAY_E;
			end
			ST_DAY_E: begin
				cmd.day = 1'b1;
				cmd.sel_end = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!status.out_stall) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/gdd_datapath.sv =====
`timescale 1ns / 1ps

module gdd_datapath (
	input logic clk,
	input logic arst_n,
	input gdd_pkg::gdd_cmd_t cmd,
	output gdd_pkg::gdd_status_t status,
	input logic [gdd_pkg::DAY_W-1:0] start_day,
	input logic [gdd_pkg::MONTH_W-1:0] start_month,
	input logic [gdd_pkg::YEAR_W-1:0] start_year,
	input logic [gdd_pkg::DAY_W-1:0] end_day,
	input logic [gdd_pkg::MONTH_W-1:0] end_month,
	input logic [gdd_pkg::YEAR_W-1:0] end_year,
	input logic include_end_day,
	output logic out_valid,
	input logic out_ready,
	output logic [gdd_pkg::COUNT_W-1:0] day_count,
	output logic invalid_date
);

	logic [gdd_pkg::DAY_W-1:0] start_day_q, end_day_q;
	logic [gdd_pkg::MONTH_W-1:0] start_month_q, end_month_q;
	logic [gdd_pkg::YEAR_W-1:0] start_year_q, end_year_q;
	logic inc_q;

	logic [gdd_pkg::Q_W-1:0] q_y_q, q_yy_q;
	logic [gdd_pkg::DN_W-1:0] dn_a_q, dn_b_q;
	logic bad_q;

	logic out_valid_q;
	logic [gdd_pkg::COUNT_W-1:0] count_q;
	logic invalid_q;

	logic [gdd_pkg::DAY_W-1:0] d_sel;
	logic [gdd_pkg::MONTH_W-1:0] m_sel;
	logic [gdd_pkg::YEAR_W-1:0] y_sel;
	logic early;
	logic [gdd_pkg::YY_W-1:0] yy;
	logic [25:0] prod_y, prod_yy;
	logic [gdd_pkg::YY_W-1:0] rem_y;
	logic leap;
	logic bad_now;
	logic [23:0] dn_sum;
	logic [gdd_pkg::DN_W-1:0] diff;
	logic [23:0] total;
	logic [gdd_pkg::COUNT_W-1:0] count_d;

	assign d_sel = cmd.sel_end ? end_day_q : start_day_q;
	assign m_sel = cmd.sel_end ? end_month_q : start_month_q;
	assign y_sel = cmd.sel_end ? end_year_q : start_year_q;

	assign early = (m_sel <= gdd_pkg::MONTH_FEB);
	assign yy = {1'b0, y_sel} + gdd_pkg::YEAR_OFFSET - {{(gdd_pkg::YY_W-1){1'b0}}, early};

	// Division by 100 as a quarter divided by 25 through the reciprocal.
	assign prod_y = {14'd0, y_sel[gdd_pkg::YEAR_W-1:2]} * {13'd0, gdd_pkg::RECIP_25};
	assign prod_yy = {13'd0, yy[gdd_pkg::YY_W-1:2]} * {13'd0, gdd_pkg::RECIP_25};

	assign rem_y = {1'b0, y_sel} - 15'({7'd0, q_y_q} * 15'd100);
	assign leap = (y_sel[1:0] == 2'b00) && ((rem_y != '0) || (q_y_q[1:0] == 2'b00));
	assign bad_now = (d_sel == '0) || (d_sel > gdd_pkg::month_length(m_sel, leap));

	assign dn_sum = 24'({9'd0, yy} * 24'd365)
		+ {11'd0, yy[gdd_pkg::YY_W-1:2]}
		- {16'd0, q_yy_q}
		+ {18'd0, q_yy_q[gdd_pkg::Q_W-1:2]}
		+ {15'd0, gdd_pkg::month_offset(m_sel)}
		+ {19'd0, d_sel}
		- 24'd1;

	assign diff = (dn_b_q > dn_a_q) ? (dn_b_q - dn_a_q) : '0;
	assign total = {1'b0, diff} + {23'd0, inc_q};
	assign count_d = (total > {2'b00, gdd_pkg::COUNT_MAX}) ? gdd_pkg::COUNT_MAX
		: total[gdd_pkg::COUNT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_day_q <= start_day;
			start_month_q <= start_month;
			start_year_q <= start_year;
			end_day_q <= end_day;
			end_month_q <= end_month;
			end_year_q <= end_year;
			inc_q <= include_end_day;
		end
		if (cmd.div) begin
			q_y_q <= prod_y[gdd_pkg::RECIP_SHIFT+gdd_pkg::Q_W-1:gdd_pkg::RECIP_SHIFT];
			q_yy_q <= prod_yy[gdd_pkg::RECIP_SHIFT+gdd_pkg::Q_W-1:gdd_pkg::RECIP_SHIFT];
		end
		if (cmd.day) begin
			if (cmd.sel_end) begin
				dn_b_q <= dn_sum[gdd_pkg::DN_W-1:0];
				bad_q <= bad_q | bad_now;
			end else begin
				dn_a_q <= dn_sum[gdd_pkg::DN_W-1:0];
				bad_q <= bad_now;
			end
		end
		if (cmd.fin) begin
			count_q <= bad_q ? '0 : count_d;
			invalid_q <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_stall = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign day_count = count_q;
	assign invalid_date = invalid_q;

endmodule

// ===== hw/rtl/gregorian_date_difference.sv =====
`timescale 1ns / 1ps
// Channel   Role    Payload
// in        sink    start_day, start_month, start_year, end_day, end_month,
//                   end_year, include_end_day
// out       source  day_count, invalid_date
//
// An item is captured, then each date goes through the shared divide-by-100
// multipliers and then the day-number adder, and a final step compares and
// saturates, after which the block is ready again.
// The result waits in an output register, so a stalled output delays only the
// final step. Reset clears the controller and the output valid flag.

`include "gregorian_date_difference_macros.svh"

module gregorian_date_difference (
	input logic clk,
	input logic arst_n,
	gdd_in_if.sink in,
	gdd_out_if.source out
);

	gdd_pkg::gdd_cmd_t cmd;
	gdd_pkg::gdd_status_t status;
	logic in_ready;

	gdd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in.valid),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	gdd_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.start_day(in.start_day),
		.start_month(in.start_month),
		.start_year(in.start_year),
		.end_day(in.end_day),
		.end_month(in.end_month),
		.end_year(in.end_year),
		.include_end_day(in.include_end_day),
		.out_valid(out.valid),
		.out_ready(out.ready),
		.day_count(out.day_count),
		.invalid_date(out.invalid_date)
	);

	assign in.ready = in_ready;

	`GDD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in.valid && in.ready, !in.ready && cmd.div)
	`GDD_ASSERT_SAME(a_one_command, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.div, cmd.day, cmd.fin}))
	`GDD_ASSERT_SAME(a_invalid_zero, clk, arst_n, out.valid && out.invalid_date, out.day_count == '0)
	`GDD_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.fin, !(out.valid && !out.ready))

endmodule
